// ===== design/dpw_pkg.sv =====
// Package for the depth pixel to world point block: shared widths, register
// indices, reset values and the camera point beat type.
// No dependencies.
package dpw_pkg;

    // Configuration register indices
    typedef enum logic [2:0] {
        CFG_ROT_ROW0  = 3'd0,
        CFG_ROT_ROW1  = 3'd1,
        CFG_ROT_ROW2  = 3'd2,
        CFG_TRANS     = 3'd3,
        CFG_PP        = 3'd4,
        CFG_INV_FOCAL = 3'd5,
        CFG_MAX_DEPTH = 3'd6
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 60;

    // Register widths
    localparam int ROT_ROW_W = 48;
    localparam int ROT_W     = 16;
    localparam int TRANS_W   = 60;
    localparam int TCOMP_W   = 20;
    localparam int PP_W      = 28;
    localparam int PPC_W     = 14;
    localparam int IFOC_W    = 48;
    localparam int IFC_W     = 24;
    localparam int DEPTH_W   = 16;

    // Field widths
    localparam int PIX_W    = 10;
    localparam int COLOUR_W = 8;
    localparam int WORLD_W  = 24;

    // Datapath widths
    localparam int DX_W   = 15;                     // 16*pix - c, Q.4
    localparam int ZS_W   = DEPTH_W + 1;            // depth as signed
    localparam int DZ_W   = DX_W + ZS_W;            // dx*z
    localparam int DZF_W  = DZ_W + IFC_W + 1;       // dx*z*inv_f, Q.28
    localparam int XC_W   = DZF_W - 20;             // camera x/y, Q.8 mm
    localparam int ZC_W   = DEPTH_W + 8 + 1;        // camera z, Q.8 mm signed
    localparam int PXY_W  = ROT_W + XC_W;
    localparam int PZ_W   = ROT_W + ZC_W;
    localparam int ACC_W  = 56;                     // world sum, Q.22 mm
    localparam int RND_W  = ACC_W - 22;

    // Reset values
    localparam logic [ROT_ROW_W-1:0] ROT_ROW0_RST  = 48'd16384;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW1_RST  = 48'd1073741824;
    localparam logic [ROT_ROW_W-1:0] ROT_ROW2_RST  = 48'd70368744177664;
    localparam logic [TRANS_W-1:0]   TRANS_RST     = 60'd0;
    localparam logic [PP_W-1:0]      PP_RST        = 28'd66458712;
    localparam logic [IFOC_W-1:0]    IFOC_RST      = 48'd542340316804;
    localparam logic [DEPTH_W-1:0]   MAX_DEPTH_RST = 16'd3500;

    localparam logic signed [WORLD_W-1:0] WORLD_MAX = 24'sh7FFFFF;
    localparam logic signed [WORLD_W-1:0] WORLD_MIN = -24'sh800000;

    // Camera-frame point, Q.8 mm
    typedef struct packed {
        logic signed [XC_W-1:0] xc;
        logic signed [XC_W-1:0] yc;
        logic signed [ZC_W-1:0] zc;
    } t_cam_point;

    typedef struct packed {
        logic [COLOUR_W-1:0] red;
        logic [COLOUR_W-1:0] green;
        logic [COLOUR_W-1:0] blue;
    } t_colour;

endpackage

// ===== design/dpw_rigid_row.sv =====
// One row of the rigid transform: dot product of a rotation row with the
// camera point, plus translation, rounding and 24-bit saturation.
// Depends on dpw_pkg. Four register stages.
module dpw_rigid_row (
    input  logic                              i_clk,
    input  logic [dpw_pkg::ROT_ROW_W-1:0]     i_rot_row,
    input  logic signed [dpw_pkg::TCOMP_W-1:0] i_trans,
    input  dpw_pkg::t_cam_point               i_pt,
    output logic signed [dpw_pkg::WORLD_W-1:0] o_world
);
    import dpw_pkg::*;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< 21);

    logic signed [ROT_W-1:0]   w_r0, w_r1, w_r2;
    logic signed [PXY_W-1:0]   r_p0, r_p1;
    logic signed [PZ_W-1:0]    r_p2;
    logic signed [TCOMP_W-1:0] r_t;
    logic signed [ACC_W-1:0]   r_sum_a, r_sum_b, r_acc;
    logic signed [ACC_W-1:0]   w_t_q22;
    logic signed [ACC_W-1:0]   w_shift;
    logic signed [WORLD_W-1:0] n_world;

    assign w_r0 = $signed(i_rot_row[ROT_W-1:0]);
    assign w_r1 = $signed(i_rot_row[2*ROT_W-1:ROT_W]);
    assign w_r2 = $signed(i_rot_row[3*ROT_W-1:2*ROT_W]);

    // Stage 1: the three products
    always_ff @(posedge i_clk) begin
        r_p0 <= PXY_W'(w_r0) * PXY_W'(i_pt.xc);
        r_p1 <= PXY_W'(w_r1) * PXY_W'(i_pt.yc);
        r_p2 <= PZ_W'(w_r2) * PZ_W'(i_pt.zc);
        r_t  <= i_trans;
    end

    // Stage 2: pairwise sums; translation moved to Q.22 with the rounding half
    assign w_t_q22 = ACC_W'(r_t) <<< 22;

    always_ff @(posedge i_clk) begin
        r_sum_a <= ACC_W'(r_p0) + ACC_W'(r_p1);
        r_sum_b <= ACC_W'(r_p2) + w_t_q22 + ROUND_HALF;
    end

    // Stage 3: full sum
    always_ff @(posedge i_clk) begin
        r_acc <= r_sum_a + r_sum_b;
    end

    // Stage 4: floor shift to mm and saturate
    assign w_shift = r_acc >>> 22;

    always_comb begin
        if (w_shift > ACC_W'(WORLD_MAX)) begin
            n_world = WORLD_MAX;
        end else if (w_shift < ACC_W'(WORLD_MIN)) begin
            n_world = WORLD_MIN;
        end else begin
            n_world = w_shift[WORLD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        o_world <= n_world;
    end

endmodule

// ===== design/depth_pixel_to_world_point.sv =====
// Top level: depth pixel back-projection through a pinhole model followed by
// a rigid transform into world coordinates. Depends on dpw_pkg and
// dpw_rigid_row.
//
//   Channel    Handshake          Payload
//   --------   ----------------   ---------------------------------------------
//   pixel in   start, busy        i_col, i_row_index, i_depth_mm, i_blue/green/red
//   point out  o_valid strobe     o_world_x/y/z, o_out_red/green/blue
//   config     i_cfg_we           i_cfg_idx, i_cfg_data
//
// One pixel per clock; busy is always low. A kept pixel appears on the
// outputs after 4 back-projection stages and 4 transform stages, with
// o_valid high for a single cycle. Dropped pixels give no strobe.
// Synchronous active-low reset clears the valid pipeline and loads the default
// calibration. The receiver cannot stall, so the pipeline never holds.
module depth_pixel_to_world_point #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [dpw_pkg::PIX_W-1:0]            i_col,
    input  logic [dpw_pkg::PIX_W-1:0]            i_row_index,
    input  logic [dpw_pkg::DEPTH_W-1:0]          i_depth_mm,
    input  logic [dpw_pkg::COLOUR_W-1:0]         i_blue,
    input  logic [dpw_pkg::COLOUR_W-1:0]         i_green,
    input  logic [dpw_pkg::COLOUR_W-1:0]         i_red,
    input  logic                                 i_cfg_we,
    input  logic [dpw_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [dpw_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                 o_valid,
    output logic signed [dpw_pkg::WORLD_W-1:0]   o_world_x,
    output logic signed [dpw_pkg::WORLD_W-1:0]   o_world_y,
    output logic signed [dpw_pkg::WORLD_W-1:0]   o_world_z,
    output logic [dpw_pkg::COLOUR_W-1:0]         o_out_red,
    output logic [dpw_pkg::COLOUR_W-1:0]         o_out_green,
    output logic [dpw_pkg::COLOUR_W-1:0]         o_out_blue
);
    import dpw_pkg::*;

    localparam int LAT = 8;
    localparam logic signed [DZF_W:0] XY_HALF = (DZF_W+1)'(64'sd1 <<< 19);

    // Calibration registers
    logic [ROT_ROW_W-1:0] r_rot0, r_rot1, r_rot2;
    logic [TRANS_W-1:0]   r_trans;
    logic [PP_W-1:0]      r_pp;
    logic [IFOC_W-1:0]    r_ifoc;
    logic [DEPTH_W-1:0]   r_max_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot0      <= ROT_ROW0_RST;
            r_rot1      <= ROT_ROW1_RST;
            r_rot2      <= ROT_ROW2_RST;
            r_trans     <= TRANS_RST;
            r_pp        <= PP_RST;
            r_ifoc      <= IFOC_RST;
            r_max_depth <= MAX_DEPTH_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ROT_ROW0:  r_rot0      <= i_cfg_data[ROT_ROW_W-1:0];
                CFG_ROT_ROW1:  r_rot1      <= i_cfg_data[ROT_ROW_W-1:0];
                CFG_ROT_ROW2:  r_rot2      <= i_cfg_data[ROT_ROW_W-1:0];
                CFG_TRANS:     r_trans     <= i_cfg_data[TRANS_W-1:0];
                CFG_PP:        r_pp        <= i_cfg_data[PP_W-1:0];
                CFG_INV_FOCAL: r_ifoc      <= i_cfg_data[IFOC_W-1:0];
                CFG_MAX_DEPTH: r_max_depth <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Pixel filter: missing, too distant or outside the frame
    logic w_keep;
    assign w_keep = start && !busy
                    && (i_depth_mm != '0)
                    && (i_depth_mm < r_max_depth)
                    && (int'(i_col) < MAX_COLS)
                    && (int'(i_row_index) < MAX_ROWS);

    // Valid and colour travel alongside the datapath
    logic [LAT-1:0] r_vld;
    t_colour        r_colour [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], w_keep};
        end
    end

    always_ff @(posedge i_clk) begin
        r_colour[0] <= '{red: i_red, green: i_green, blue: i_blue};
        for (int i = 1; i < LAT; i++) begin
            r_colour[i] <= r_colour[i-1];
        end
    end

    // Stage 1: offsets from the principal point, Q.4 pixels
    logic signed [DX_W-1:0] r_dx, r_dy;
    logic [DEPTH_W-1:0]     r_z1;

    always_ff @(posedge i_clk) begin
        r_dx <= $signed({1'b0, i_col, 4'b0})
                - $signed({1'b0, r_pp[PPC_W-1:0]});
        r_dy <= $signed({1'b0, i_row_index, 4'b0})
                - $signed({1'b0, r_pp[2*PPC_W-1:PPC_W]});
        r_z1 <= i_depth_mm;
    end

    // Stage 2: offset times depth
    logic signed [DZ_W-1:0] r_dxz, r_dyz;
    logic [DEPTH_W-1:0]     r_z2;

    always_ff @(posedge i_clk) begin
        r_dxz <= DZ_W'(r_dx) * DZ_W'($signed({1'b0, r_z1}));
        r_dyz <= DZ_W'(r_dy) * DZ_W'($signed({1'b0, r_z1}));
        r_z2  <= r_z1;
    end

    // Stage 3: scale by the reciprocal focal lengths, Q.28
    logic signed [DZF_W-1:0] r_xf, r_yf;
    logic [DEPTH_W-1:0]      r_z3;

    always_ff @(posedge i_clk) begin
        r_xf <= DZF_W'(r_dxz) * DZF_W'($signed({1'b0, r_ifoc[IFC_W-1:0]}));
        r_yf <= DZF_W'(r_dyz) * DZF_W'($signed({1'b0, r_ifoc[2*IFC_W-1:IFC_W]}));
        r_z3 <= r_z2;
    end

    // Stage 4: round half up to Q.8 mm
    logic signed [DZF_W:0] w_xr, w_yr;
    t_cam_point            r_pt;

    assign w_xr = (DZF_W+1)'(r_xf) + XY_HALF;
    assign w_yr = (DZF_W+1)'(r_yf) + XY_HALF;

    always_ff @(posedge i_clk) begin
        r_pt.xc <= w_xr[DZF_W-1:20];
        r_pt.yc <= w_yr[DZF_W-1:20];
        r_pt.zc <= $signed({1'b0, r_z3, 8'b0});
    end

    // Stages 5 to 8: rigid transform, one unit per world axis
    dpw_rigid_row u_row_x (
        .i_clk     (i_clk),
        .i_rot_row (r_rot0),
        .i_trans   ($signed(r_trans[TCOMP_W-1:0])),
        .i_pt      (r_pt),
        .o_world   (o_world_x)
    );

    dpw_rigid_row u_row_y (
        .i_clk     (i_clk),
        .i_rot_row (r_rot1),
        .i_trans   ($signed(r_trans[2*TCOMP_W-1:TCOMP_W])),
        .i_pt      (r_pt),
        .o_world   (o_world_y)
    );

    dpw_rigid_row u_row_z (
        .i_clk     (i_clk),
        .i_rot_row (r_rot2),
        .i_trans   ($signed(r_trans[3*TCOMP_W-1:2*TCOMP_W])),
        .i_pt      (r_pt),
        .o_world   (o_world_z)
    );

    // Output beat
    assign o_valid     = r_vld[LAT-1];
    assign o_out_red   = r_colour[LAT-1].red;
    assign o_out_green = r_colour[LAT-1].green;
    assign o_out_blue  = r_colour[LAT-1].blue;

endmodule
